// File: src/cmcg_pkg.sv
// Shared types, constants and the control program of the color matrix coefficient generator.
// Holds the matrix and sine tables, control word layout and microcode ROM.
// No dependencies; used by cmcg_seq, cmcg_dp and color_matrix_coefficient_gen.
`timescale 1ns / 1ps

package cmcg_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SATURATION = 2'd0;
  localparam logic [1:0] CFG_TINT       = 2'd1;
  localparam logic [1:0] CFG_SOURCE     = 2'd2;

  // scratch file: fixed operands, intermediate matrix elements, gain-stage base
  localparam int SCR_N  = 17;
  localparam int SCR_AW = $clog2(SCR_N);

  localparam logic [SCR_AW-1:0] SC_CON  = SCR_AW'(0);
  localparam logic [SCR_AW-1:0] SC_COS  = SCR_AW'(1);
  localparam logic [SCR_AW-1:0] SC_SIN  = SCR_AW'(2);
  localparam logic [SCR_AW-1:0] SC_NSIN = SCR_AW'(3);
  localparam logic [SCR_AW-1:0] SC_UV11 = SCR_AW'(4);
  localparam logic [SCR_AW-1:0] SC_UV12 = SCR_AW'(5);
  localparam logic [SCR_AW-1:0] SC_UV21 = SCR_AW'(6);
  localparam logic [SCR_AW-1:0] SC_ADJ  = SCR_AW'(7);
  localparam logic [SCR_AW-1:0] SC_BASE = SCR_AW'(16);

  // second multiplier operand codes
  localparam int BSEL_W = 5;
  localparam logic [BSEL_W-1:0] B_YUV   = BSEL_W'(0);
  localparam logic [BSEL_W-1:0] B_RGB   = BSEL_W'(9);
  localparam logic [BSEL_W-1:0] B_S5    = BSEL_W'(18);
  localparam logic [BSEL_W-1:0] B_GAIN0 = BSEL_W'(19);
  localparam logic [BSEL_W-1:0] B_GAIN1 = BSEL_W'(20);
  localparam logic [BSEL_W-1:0] B_GAIN2 = BSEL_W'(21);

  localparam logic [15:0] MAG_FLAG = 16'hF400;

  localparam int UC_AW = 6;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_LOAD = 2'd1,
    SEQ_END  = 2'd2
  } seq_op_t;

  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_RND  = 2'd1,
    WB_BASE = 2'd2,
    WB_OUT  = 2'd3
  } wb_t;

  typedef struct packed {
    seq_op_t             seq;
    logic                mul;
    logic                first;
    wb_t                 wb;
    logic [SCR_AW-1:0]   a_sel;
    logic [BSEL_W-1:0]   b_sel;
    logic [SCR_AW-1:0]   dst;
    logic [1:0]          row;
    logic [1:0]          col;
    logic                last;
  } uc_word_t;

  // operands loaded into the datapath at the start of a run
  typedef struct packed {
    logic signed [15:0] con32;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic signed [15:0] nsn;
    logic signed [15:0] s5;
    logic [2:0][15:0]   gain16;
  } ld_t;

  localparam logic signed [15:0] YUV_M [9] = '{
    16'sh041B,  16'sh0810,  16'sh0191,
    -16'sh025F, -16'sh04A7, 16'sh0707,
    16'sh0707,  -16'sh05E2, -16'sh0124
  };

  localparam logic signed [15:0] RGB_M [9] = '{
    16'sh12A1, 16'sh0000,  16'sh1989,
    16'sh12A1, -16'sh0644, -16'sh0D01,
    16'sh12A1, 16'sh2046,  16'sh0000
  };

  localparam logic [12:0] QWAVE [65] = '{
    13'h0000,13'h0064,13'h00C9,13'h012D,13'h0191,13'h01F5,13'h0259,13'h02BC,
    13'h031F,13'h0381,13'h03E3,13'h0444,13'h04A5,13'h0505,13'h0564,13'h05C2,
    13'h061F,13'h067B,13'h06D7,13'h0731,13'h078A,13'h07E3,13'h083A,13'h088F,
    13'h08E3,13'h0937,13'h0988,13'h09D8,13'h0A26,13'h0A73,13'h0ABF,13'h0B08,
    13'h0B50,13'h0B97,13'h0BDB,13'h0C1E,13'h0C5E,13'h0C9D,13'h0CDA,13'h0D15,
    13'h0D4D,13'h0D85,13'h0DB9,13'h0DEC,13'h0E1C,13'h0E4B,13'h0E77,13'h0EA1,
    13'h0EC8,13'h0EEE,13'h0F10,13'h0F31,13'h0F4F,13'h0F6C,13'h0F85,13'h0F9C,
    13'h0FB1,13'h0FC4,13'h0FD4,13'h0FE1,13'h0FEC,13'h0FF5,13'h0FFB,13'h0FFE,
    13'h1000
  };

  function automatic logic signed [13:0] wave_sin(input logic [7:0] a);
    logic [6:0]         idx;
    logic signed [13:0] m;
    idx = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
    m   = $signed({1'b0, QWAVE[idx]});
    return a[7] ? -m : m;
  endfunction

  function automatic logic signed [15:0] b_const(input logic [BSEL_W-1:0] code);
    logic [BSEL_W-1:0] off;
    off = code - B_RGB;
    if (code < B_RGB) begin
      return YUV_M[code[3:0]];
    end else if (code < B_S5) begin
      return RGB_M[off[3:0]];
    end else begin
      return 16'sd0;
    end
  endfunction

  function automatic logic [SCR_AW-1:0] sc_adj(input int k, input int j);
    return SC_ADJ + SCR_AW'(3 * k + j);
  endfunction

  function automatic logic [BSEL_W-1:0] b_yuv(input int k, input int j);
    return B_YUV + BSEL_W'(3 * k + j);
  endfunction

  function automatic logic [BSEL_W-1:0] b_rgb(input int i, input int k);
    return B_RGB + BSEL_W'(3 * i + k);
  endfunction

  function automatic uc_word_t uc_mk(input seq_op_t seq, input logic mul, input logic first,
                                     input wb_t wb, input logic [SCR_AW-1:0] a,
                                     input logic [BSEL_W-1:0] b, input logic [SCR_AW-1:0] dst,
                                     input logic [1:0] row, input logic [1:0] col,
                                     input logic last);
    uc_word_t w;
    w.seq   = seq;
    w.mul   = mul;
    w.first = first;
    w.wb    = wb;
    w.a_sel = a;
    w.b_sel = b;
    w.dst   = dst;
    w.row   = row;
    w.col   = col;
    w.last  = last;
    return w;
  endfunction

  function automatic uc_word_t uc_nop();
    return uc_mk(SEQ_NEXT, 1'b0, 1'b0, WB_NONE, SC_CON, B_S5, SC_CON, 2'd0, 2'd0, 1'b0);
  endfunction

  function automatic uc_word_t uc_seq(input seq_op_t seq);
    return uc_mk(seq, 1'b0, 1'b0, WB_NONE, SC_CON, B_S5, SC_CON, 2'd0, 2'd0, 1'b0);
  endfunction

  function automatic uc_word_t uc_term(input logic [SCR_AW-1:0] a, input logic [BSEL_W-1:0] b,
                                       input logic first, input wb_t wb,
                                       input logic [SCR_AW-1:0] dst);
    return uc_mk(SEQ_NEXT, 1'b1, first, wb, a, b, dst, 2'd0, 2'd0, 1'b0);
  endfunction

  // one term of the output-matrix dot product: column j of the adjusted matrix, row i of RGB
  function automatic uc_word_t uc_res(input int i, input int j, input int k);
    if (k == 0) begin
      return uc_term(sc_adj(0, j), b_rgb(i, 0), 1'b1, WB_NONE, SC_BASE);
    end else if (k == 1) begin
      return uc_term(sc_adj(1, j), b_rgb(i, 1), 1'b0, WB_NONE, SC_BASE);
    end else begin
      return uc_term(sc_adj(2, j), b_rgb(i, 2), 1'b0, WB_BASE, SC_BASE);
    end
  endfunction

  // gain stage of one element: base times row gain, sent out
  function automatic uc_word_t uc_out(input int i, input int j);
    logic [BSEL_W-1:0] g;
    case (i)
      0:       g = B_GAIN0;
      1:       g = B_GAIN1;
      default: g = B_GAIN2;
    endcase
    return uc_mk(SEQ_NEXT, 1'b1, 1'b1, WB_OUT, SC_BASE, g, SC_BASE, 2'(i), 2'(j),
                 (i == 2) && (j == 2));
  endfunction

  // Control program. A written-back result passes the product, accumulator and write-back registers.
  function automatic uc_word_t ucode(input logic [UC_AW-1:0] step);
    case (step)
      6'd0:  return uc_seq(SEQ_LOAD);
      // hue rotation and saturation of the chroma rows
      6'd1:  return uc_term(SC_COS,  B_S5, 1'b1, WB_RND, SC_UV11);
      6'd2:  return uc_term(SC_SIN,  B_S5, 1'b1, WB_RND, SC_UV12);
      6'd3:  return uc_term(SC_NSIN, B_S5, 1'b1, WB_RND, SC_UV21);
      // luma row from contrast
      6'd4:  return uc_term(SC_CON, b_yuv(0, 0), 1'b1, WB_RND, sc_adj(0, 0));
      6'd5:  return uc_term(SC_CON, b_yuv(0, 1), 1'b1, WB_RND, sc_adj(0, 1));
      6'd6:  return uc_term(SC_CON, b_yuv(0, 2), 1'b1, WB_RND, sc_adj(0, 2));
      // chroma rows times the RGB-to-YUV matrix
      6'd7:  return uc_term(SC_UV11, b_yuv(1, 0), 1'b1, WB_NONE, SC_CON);
      6'd8:  return uc_term(SC_UV12, b_yuv(2, 0), 1'b0, WB_RND, sc_adj(1, 0));
      6'd9:  return uc_term(SC_UV11, b_yuv(1, 1), 1'b1, WB_NONE, SC_CON);
      6'd10: return uc_term(SC_UV12, b_yuv(2, 1), 1'b0, WB_RND, sc_adj(1, 1));
      6'd11: return uc_term(SC_UV11, b_yuv(1, 2), 1'b1, WB_NONE, SC_CON);
      6'd12: return uc_term(SC_UV12, b_yuv(2, 2), 1'b0, WB_RND, sc_adj(1, 2));
      6'd13: return uc_term(SC_UV21, b_yuv(1, 0), 1'b1, WB_NONE, SC_CON);
      6'd14: return uc_term(SC_UV11, b_yuv(2, 0), 1'b0, WB_RND, sc_adj(2, 0));
      6'd15: return uc_term(SC_UV21, b_yuv(1, 1), 1'b1, WB_NONE, SC_CON);
      6'd16: return uc_term(SC_UV11, b_yuv(2, 1), 1'b0, WB_RND, sc_adj(2, 1));
      6'd17: return uc_term(SC_UV21, b_yuv(1, 2), 1'b1, WB_NONE, SC_CON);
      6'd18: return uc_term(SC_UV11, b_yuv(2, 2), 1'b0, WB_RND, sc_adj(2, 2));
      // output matrix, each element after the first followed by the gain stage of the one before
      6'd19: return uc_res(0, 0, 0);
      6'd20: return uc_res(0, 0, 1);
      6'd21: return uc_res(0, 0, 2);
      6'd22: return uc_nop();
      6'd23: return uc_res(0, 1, 0);
      6'd24: return uc_res(0, 1, 1);
      6'd25: return uc_res(0, 1, 2);
      6'd26: return uc_out(0, 0);
      6'd27: return uc_res(0, 2, 0);
      6'd28: return uc_res(0, 2, 1);
      6'd29: return uc_res(0, 2, 2);
      6'd30: return uc_out(0, 1);
      6'd31: return uc_res(1, 0, 0);
      6'd32: return uc_res(1, 0, 1);
      6'd33: return uc_res(1, 0, 2);
      6'd34: return uc_out(0, 2);
      6'd35: return uc_res(1, 1, 0);
      6'd36: return uc_res(1, 1, 1);
      6'd37: return uc_res(1, 1, 2);
      6'd38: return uc_out(1, 0);
      6'd39: return uc_res(1, 2, 0);
      6'd40: return uc_res(1, 2, 1);
      6'd41: return uc_res(1, 2, 2);
      6'd42: return uc_out(1, 1);
      6'd43: return uc_res(2, 0, 0);
      6'd44: return uc_res(2, 0, 1);
      6'd45: return uc_res(2, 0, 2);
      6'd46: return uc_out(1, 2);
      6'd47: return uc_res(2, 1, 0);
      6'd48: return uc_res(2, 1, 1);
      6'd49: return uc_res(2, 1, 2);
      6'd50: return uc_out(2, 0);
      6'd51: return uc_res(2, 2, 0);
      6'd52: return uc_res(2, 2, 1);
      6'd53: return uc_res(2, 2, 2);
      6'd54: return uc_out(2, 1);
      6'd55: return uc_nop();
      6'd56: return uc_out(2, 2);
      6'd57: return uc_nop();
      6'd58: return uc_seq(SEQ_END);
      default: return uc_seq(SEQ_END);
    endcase
  endfunction

endpackage

// File: src/cmcg_seq.sv
// Microcode sequencer: step counter over the control program ROM.
// Depends on cmcg_pkg for the control word type and program.
`timescale 1ns / 1ps

module cmcg_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                stall,
  output logic                ready,
  output cmcg_pkg::uc_word_t  ctrl
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } sq_state_t;

  sq_state_t                    state_r, state_nxt;
  logic [cmcg_pkg::UC_AW-1:0]   step_r, step_nxt;
  cmcg_pkg::uc_word_t           uc;

  always_comb begin
    uc    = cmcg_pkg::ucode(step_r);
    ctrl  = (state_r == SQ_RUN) ? uc : cmcg_pkg::uc_nop();
    ready = (state_r == SQ_IDLE);
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_RUN;
          step_nxt  = '0;
        end
      end
      SQ_RUN: begin
        // hold the step while the output register blocks the gain stage
        if (!stall) begin
          if (uc.seq == cmcg_pkg::SEQ_END) begin
            state_nxt = SQ_IDLE;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + cmcg_pkg::UC_AW'(1);
          end
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: src/cmcg_dp.sv
// Datapath: scratch file, shared 16x16 multiplier, accumulator, rounding and output word.
// Driven by control words from cmcg_seq; depends on cmcg_pkg.
`timescale 1ns / 1ps

module cmcg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cmcg_pkg::uc_word_t  ctrl,
  input  cmcg_pkg::ld_t       ld,
  input  logic                out_tready,
  output logic                stall,
  output logic                out_tvalid,
  output logic [15:0]         out_tdata,   // coefficient
  output logic [3:0]          out_tuser,   // [1:0] row, [3:2] column
  output logic                out_tlast
);

  typedef struct packed {
    logic                          mul;
    logic                          first;
    cmcg_pkg::wb_t                 wb;
    logic [cmcg_pkg::SCR_AW-1:0]   dst;
    logic [1:0]                    row;
    logic [1:0]                    col;
    logic                          last;
  } pipe_t;

  logic signed [15:0] scr_r [cmcg_pkg::SCR_N];
  logic signed [15:0] s5_r;
  logic [2:0][15:0]   gain_r;

  logic signed [15:0] a_op, b_op;
  logic signed [31:0] prod, p_r;
  logic signed [33:0] acc_r, acc_nxt, rnd_sum;
  logic signed [21:0] rnd, nrnd;
  logic [15:0]        r16, b16, base16, word;
  logic               en;
  pipe_t              s2_r, s2_nxt, s3_r;

  logic               out_valid_r;
  logic [15:0]        out_word_r;
  logic [1:0]         out_row_r, out_col_r;
  logic               out_last_r;

  always_comb begin
    a_op = scr_r[ctrl.a_sel];
    case (ctrl.b_sel)
      cmcg_pkg::B_S5:    b_op = s5_r;
      cmcg_pkg::B_GAIN0: b_op = $signed(gain_r[0]);
      cmcg_pkg::B_GAIN1: b_op = $signed(gain_r[1]);
      cmcg_pkg::B_GAIN2: b_op = $signed(gain_r[2]);
      default:           b_op = cmcg_pkg::b_const(ctrl.b_sel);
    endcase
    prod = a_op * b_op;

    s2_nxt.mul   = ctrl.mul;
    s2_nxt.first = ctrl.first;
    s2_nxt.wb    = ctrl.mul ? ctrl.wb : cmcg_pkg::WB_NONE;
    s2_nxt.dst   = ctrl.dst;
    s2_nxt.row   = ctrl.row;
    s2_nxt.col   = ctrl.col;
    s2_nxt.last  = ctrl.last;

    if (!s2_r.mul) begin
      acc_nxt = acc_r;
    end else if (s2_r.first) begin
      acc_nxt = 34'(p_r);
    end else begin
      acc_nxt = acc_r + 34'(p_r);
    end

    // round: add half, floor-shift by 12
    rnd_sum = acc_r + 34'sd2048;
    rnd     = rnd_sum[33:12];
    nrnd    = -rnd;
    r16     = rnd[15:0];
    b16     = r16 + 16'd8;
    base16  = {{4{b16[15]}}, b16[15:4]};
    word    = rnd[21] ? (nrnd[15:0] | cmcg_pkg::MAG_FLAG) : rnd[15:0];

    // freeze everything while a finished word waits on the output and the next one would replace it
    stall = (s3_r.wb == cmcg_pkg::WB_OUT) && out_valid_r && !out_tready;
    en    = !stall;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= prod;
      acc_r <= acc_nxt;
      if (ctrl.seq == cmcg_pkg::SEQ_LOAD) begin
        scr_r[cmcg_pkg::SC_CON]  <= ld.con32;
        scr_r[cmcg_pkg::SC_COS]  <= ld.cs;
        scr_r[cmcg_pkg::SC_SIN]  <= ld.sn;
        scr_r[cmcg_pkg::SC_NSIN] <= ld.nsn;
        s5_r                     <= ld.s5;
        gain_r                   <= ld.gain16;
      end
      case (s3_r.wb)
        cmcg_pkg::WB_RND:  scr_r[s3_r.dst] <= r16;
        cmcg_pkg::WB_BASE: scr_r[s3_r.dst] <= base16;
        default: begin
        end
      endcase
      if (s3_r.wb == cmcg_pkg::WB_OUT) begin
        out_word_r <= word;
        out_row_r  <= s3_r.row;
        out_col_r  <= s3_r.col;
        out_last_r <= s3_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r        <= '0;
      s3_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s2_r <= s2_nxt;
        s3_r <= s2_r;
      end
      if (en && (s3_r.wb == cmcg_pkg::WB_OUT)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = {out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

// File: src/color_matrix_coefficient_gen.sv
// Top level of the color matrix coefficient generator: configuration registers,
// saturation and hue preparation, input capture. Uses cmcg_pkg, cmcg_seq and cmcg_dp.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    tdata: contrast, red, green, blue gain
//   out_     master     out_tvalid/out_tready  tdata: coefficient; tuser: row, column;
//                                              tlast: ninth word
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item gives nine words after a 59-step control program; in_tready rises again only
// once the sequencer is back in idle, so no new item is taken while one is in progress.
// The run length is set by the single shared 16x16 multiplier issuing at most one product
// per step (54 products) unless stalled, and by the multiply, accumulate, write-back
// pipeline.
// rst_n is synchronous; registers reset to saturation 50, tint 50, source 0.
// With the next word due, a stalled output word freezes datapath and sequencer until taken.
`timescale 1ns / 1ps

module color_matrix_coefficient_gen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [7:0] contrast, [15:8] red_gain, [23:16] green_gain,
                                   // [31:24] blue_gain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] coefficient
  output logic [3:0]  out_tuser,   // [1:0] row, [3:2] column
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [2:0] SRC_FIXED_MIN  = 3'd3;
  localparam logic [8:0] FIXED_SAT      = 9'd220;
  localparam logic [6:0] SAT_RESET      = 7'd50;
  localparam logic [6:0] TINT_RESET     = 7'd50;

  // x / 100 for x below 2^15: reciprocal 5243 / 2^19 is exact over this range
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[27:19];
  endfunction

  logic [6:0]  sat_r, tint_r;
  logic [2:0]  src_r;
  logic [8:0]  ss_r, ss_nxt;
  logic [7:0]  hh_r, hh_nxt;
  logic [8:0]  tint_q;
  logic [7:0]  con_r;
  logic [2:0][7:0] gbyte_r;

  logic        in_acc, seq_ready, stall;
  logic [10:0] c5;
  logic [8:0]  gain9 [3];
  cmcg_pkg::ld_t      ld;
  cmcg_pkg::uc_word_t ctrl;

  // take no word while reset is held
  assign cfg_ready = rst_n;
  assign in_tready = seq_ready && rst_n;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r  <= SAT_RESET;
      tint_r <= TINT_RESET;
      src_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cmcg_pkg::CFG_SATURATION: sat_r  <= cfg_data;
        cmcg_pkg::CFG_TINT:       tint_r <= cfg_data;
        cmcg_pkg::CFG_SOURCE:     src_r  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tint_q = div100({tint_r, 8'd0} + 15'd50);
    if (src_r < SRC_FIXED_MIN) begin
      ss_nxt = div100({sat_r, 8'd0} + 15'd50);
      hh_nxt = tint_q[7:0] ^ 8'h80;   // subtract 128 modulo 256
    end else begin
      ss_nxt = FIXED_SAT;
      hh_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    ss_r <= ss_nxt;
    hh_r <= hh_nxt;
    if (in_acc) begin
      con_r      <= in_tdata[7:0];
      gbyte_r[0] <= in_tdata[15:8];
      gbyte_r[1] <= in_tdata[23:16];
      gbyte_r[2] <= in_tdata[31:24];
    end
  end

  always_comb begin
    c5       = 11'(con_r) * 11'd5;
    ld.con32 = $signed({1'b0, c5[10:1], 5'd0});
    ld.s5    = $signed({2'b0, ss_r, 5'd0});
    ld.cs    = 16'(cmcg_pkg::wave_sin(hh_r + 8'd64));
    ld.sn    = 16'(cmcg_pkg::wave_sin(hh_r));
    ld.nsn   = -ld.sn;
    for (int i = 0; i < 3; i++) begin
      gain9[i]     = {1'b0, gbyte_r[i]} + 9'd128;
      ld.gain16[i] = {3'b0, gain9[i], 4'd0};
    end
  end

  cmcg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .stall (stall),
    .ready (seq_ready),
    .ctrl  (ctrl)
  );

  cmcg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .ld         (ld),
    .out_tready (out_tready),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: bench/testbench.sv
// Self-checking bench for color_matrix_coefficient_gen: drives gain words and register writes,
// predicts the nine coefficient words of each item and compares them as they come out.
// Depends only on the RTL in src/ (cmcg_pkg and the top level).
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REG_UNUSED     = 2'd3;

  localparam logic [15:0] NEG_FLAG   = 16'hF400;
  localparam int          IDLE_LIMIT = 5000;
  localparam int          TAIL_WAIT  = 8;

  localparam int YUV_K [3][3] = '{
    '{ 'h041B,  'h0810,  'h0191},
    '{-'h025F, -'h04A7,  'h0707},
    '{ 'h0707, -'h05E2, -'h0124}
  };

  localparam int RGB_K [3][3] = '{
    '{'h12A1,  'h0000,  'h1989},
    '{'h12A1, -'h0644, -'h0D01},
    '{'h12A1,  'h2046,  'h0000}
  };

  localparam int QUARTER_SINE [65] = '{
    'h0000,'h0064,'h00C9,'h012D,'h0191,'h01F5,'h0259,'h02BC,'h031F,'h0381,
    'h03E3,'h0444,'h04A5,'h0505,'h0564,'h05C2,'h061F,'h067B,'h06D7,'h0731,
    'h078A,'h07E3,'h083A,'h088F,'h08E3,'h0937,'h0988,'h09D8,'h0A26,'h0A73,
    'h0ABF,'h0B08,'h0B50,'h0B97,'h0BDB,'h0C1E,'h0C5E,'h0C9D,'h0CDA,'h0D15,
    'h0D4D,'h0D85,'h0DB9,'h0DEC,'h0E1C,'h0E4B,'h0E77,'h0EA1,'h0EC8,'h0EEE,
    'h0F10,'h0F31,'h0F4F,'h0F6C,'h0F85,'h0F9C,'h0FB1,'h0FC4,'h0FD4,'h0FE1,
    'h0FEC,'h0FF5,'h0FFB,'h0FFE,'h1000
  };

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  column;
    logic [15:0] coefficient;
    logic        last;
  } coef_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [6:0]  cfg_data   = '0;

  // register shadow for the predictor
  logic [6:0] sat_reg  = 7'd50;
  logic [6:0] tint_reg = 7'd50;
  logic [2:0] src_reg  = 3'd0;

  coef_word_t pending_words[$];
  int         errors     = 0;
  int         stall_pct  = 0;
  int         gap_max    = 0;
  int         burst_left = 0;
  int         hold_len   = 0;
  int         hold_left  = 0;

  color_matrix_coefficient_gen u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint wrap16(input longint v);
    logic signed [15:0] t16;
    t16 = v[15:0];
    return longint'(t16);
  endfunction

  function automatic longint round12(input longint v);
    return wrap16((v + 2048) >>> 12);
  endfunction

  function automatic longint hue_sine(input logic [7:0] a);
    int v;
    v = int'(a[5:0]);
    case (a[7:6])
      2'd0:    return QUARTER_SINE[v];
      2'd1:    return QUARTER_SINE[64 - v];
      2'd2:    return -QUARTER_SINE[v];
      default: return -QUARTER_SINE[64 - v];
    endcase
  endfunction

  // Build the nine coefficient words for one gain word under the current registers.
  task automatic predict_matrix(input logic [31:0] d);
    longint     con, s5, cs, sn, acc, base, t;
    longint     gain [3];
    longint     uv   [3][3];
    longint     adj  [3][3];
    longint     res  [3][3];
    int         ss, hh;
    coef_word_t w;
    con = longint'(d[7:0]) * 25 / 10;
    for (int i = 0; i < 3; i++) gain[i] = longint'(d[8*(i+1) +: 8]) + 128;
    if (src_reg < 3'd3) begin
      ss = (int'(sat_reg) * 256 + 50) / 100;
      hh = ((int'(tint_reg) * 256 + 50) / 100 + 128) & 255;
    end else begin
      ss = 220;
      hh = 0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) uv[i][j] = 0;
    s5 = longint'(ss) * 32;
    cs = hue_sine(8'(hh + 64));
    sn = hue_sine(8'(hh));
    uv[1][1] = round12(s5 * cs);
    uv[1][2] = round12(s5 * sn);
    uv[2][1] = round12(-sn * s5);
    uv[2][2] = round12(cs * s5);
    for (int j = 0; j < 3; j++) begin
      adj[0][j] = round12(longint'(YUV_K[0][j]) * (con * 32));
      for (int i = 1; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += uv[i][k] * longint'(YUV_K[k][j]);
        adj[i][j] = round12(acc);
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += longint'(RGB_K[i][k]) * adj[k][j];
        res[i][j] = round12(acc);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        base = wrap16(res[i][j] + 8) >>> 4;
        t = (base * (gain[i] * 16) + 2048) >>> 12;
        w.row         = 2'(i);
        w.column      = 2'(j);
        w.coefficient = (t < 0) ? (16'(-t) | NEG_FLAG) : 16'(t);
        w.last        = (i == 2) && (j == 2);
        pending_words.push_back(w);
      end
  endtask

  // Offer one gain word; bursts end in a random gap when gaps are enabled.
  task automatic send_gains(input logic [31:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    predict_matrix(d);
  endtask

  // keep: leave cfg_valid high for a write that follows right away
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val, input bit keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!keep) cfg_valid <= 1'b0;
    case (idx)
      cmcg_pkg::CFG_SATURATION: sat_reg  = val;
      cmcg_pkg::CFG_TINT:       tint_reg = val;
      cmcg_pkg::CFG_SOURCE:     src_reg  = val[2:0];
      default:        ;
    endcase
  endtask

  task automatic program_regs(input logic [6:0] sat, input logic [6:0] tint,
                              input logic [6:0] src);
    write_reg(cmcg_pkg::CFG_SATURATION, sat, 1'b1);
    write_reg(cmcg_pkg::CFG_TINT, tint, 1'b1);
    write_reg(cmcg_pkg::CFG_SOURCE, src, 1'b0);
  endtask

  // Drop the input valid and wait until every predicted word has been taken.
  task automatic drain_words();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  function automatic logic [7:0] gain_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_gains();
    return {gain_byte(), gain_byte(), gain_byte(), gain_byte()};
  endfunction

  task automatic test_reset_registers();
    send_gains(32'h0000_0000);
    send_gains(32'hFFFF_FFFF);
    send_gains(32'h8080_8080);
    send_gains(32'h55AA_55AA);
    send_gains(32'hAA55_AA55);
    drain_words();
  endtask

  task automatic test_register_extremes();
    program_regs(7'd0, 7'd0, 7'd0);
    send_gains(32'hFF00_80FF);
    send_gains(32'h00FF_0001);
    drain_words();
    // values past 100 percent go through the same formulas unclamped
    program_regs(7'd127, 7'd127, 7'd2);
    send_gains(32'hFFFF_FFFF);
    send_gains(32'h0000_0000);
    drain_words();
    program_regs(7'd100, 7'd100, 7'd1);
    send_gains(32'h7F80_7F80);
    drain_words();
    // sources 3 and up ignore saturation and tint
    program_regs(7'd13, 7'd77, 7'd3);
    send_gains(32'h1234_56C8);
    drain_words();
    program_regs(7'd127, 7'd0, 7'd7);
    send_gains(32'hFFFF_FF00);
    drain_words();
    // index 3 is no register: nothing may change
    write_reg(REG_UNUSED, 7'h7F, 1'b1);
    write_reg(cmcg_pkg::CFG_SOURCE, 7'h7A, 1'b0);
    send_gains(32'h00FF_00FF);
    send_gains(32'hC0C0_C0C0);
    drain_words();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) program_regs(7'd0, 7'd127, 7'($urandom_range(0, 2)));
      else program_regs(7'($urandom), 7'($urandom), 7'($urandom));
      case (phase % 3)
        0: begin stall_pct = 0;  gap_max = 0;  end
        1: begin stall_pct = 25; gap_max = 3;  end
        default: begin stall_pct = 60; gap_max = 12; end
      endcase
      repeat (15) send_gains(random_gains());
      drain_words();
    end
  endtask

  // Hold the output for a long stretch while items keep coming, so the input stalls.
  task automatic test_output_hold();
    stall_pct = 10;
    gap_max   = 0;
    hold_len  = 400;
    repeat (6) send_gains(random_gains());
    drain_words();
  endtask

  always @(posedge clk) begin
    coef_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: coefficient %h", out_tdata);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_tuser[1:0] !== w.row) begin
          $error("row: expected %0d, got %0d", w.row, out_tuser[1:0]);
          errors++;
        end
        if (out_tuser[3:2] !== w.column) begin
          $error("column: expected %0d, got %0d", w.column, out_tuser[3:2]);
          errors++;
        end
        if (out_tdata !== w.coefficient) begin
          $error("coefficient: expected %h, got %h", w.coefficient, out_tdata);
          errors++;
        end
        if (out_tlast !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, out_tlast);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_left = hold_len - 1;
      hold_len  = 0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Count cycles with no word moving on any channel.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_registers();
    test_register_extremes();
    test_random_settings();
    test_output_hold();
    drain_words();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/cmcg_pkg.sv
src/cmcg_seq.sv
src/cmcg_dp.sv
src/color_matrix_coefficient_gen.sv
bench/testbench.sv
